// ===== rtl/mkdar_pkg.sv =====
// Shared constants and types for the multi-key debounce and auto-repeat unit.
`default_nettype none

package mkdar_pkg;

    // Key count and event queue depth.
    localparam int NUM_KEYS    = 10;
    localparam int QUEUE_DEPTH = 16;

    // Fixed field widths.
    localparam int KEY_W   = 4;
    localparam int CNT_W   = 4;
    localparam int TMR_W   = 16;
    localparam int DROP_W  = 4;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Derived widths for the queue and the push compaction.
    localparam int CAND_N = 2 * NUM_KEYS;
    localparam int POS_W  = $clog2(CAND_N + 1);
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QSUM_W = QPTR_W + 1;
    localparam int CMP_W  = (POS_W > QSUM_W) ? POS_W : QSUM_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 2'd2;

    // Configuration reset values.
    localparam logic [CNT_W-1:0] RST_DEBOUNCE = 4'd3;
    localparam logic [TMR_W-1:0] RST_DELAY    = 16'd100;
    localparam logic [TMR_W-1:0] RST_RATE     = 16'd20;

    // Word function codes.
    localparam logic FUNC_SCAN = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Auto-repeat phase of one key.
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_DELAY  = 2'd1,
        PH_REPEAT = 2'd2
    } t_phase;

endpackage

`default_nettype wire

// ===== rtl/multi_key_debounce_autorepeat_unit.sv =====
// Top level of the multi-key debounce and auto-repeat unit with its event queue.
// A word accepted into the input register is computed and its result is presented from
// the result register, which holds it while the output side stalls.
// Throughput: one word per cycle while the output is not stalled; all keys update in
// parallel and queue pushes are compacted by a prefix count in the single compute stage.
// Reset (synchronous, active low) clears keys, timers, queue pointers and the
// configuration registers to their defaults; queue entries are not cleared.
`default_nettype none

module multi_key_debounce_autorepeat_unit
    import mkdar_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    // Input channel.
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_func,
    input  wire logic [NUM_KEYS-1:0]   i_raw_keys,
    // Output channel.
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_event_valid,
    output logic [KEY_W-1:0]           o_event_key,
    output logic [NUM_KEYS-1:0]        o_stable_keys,
    output logic                       o_queue_empty,
    output logic [DROP_W-1:0]          o_dropped_events
);

    // Configuration registers.
    logic [CNT_W-1:0] r_debounce;
    logic [TMR_W-1:0] r_delay;
    logic [TMR_W-1:0] r_rate;

    // Input register.
    logic                r_in_valid;
    logic                r_func;
    logic [NUM_KEYS-1:0] r_raw;

    // Key state.
    logic [CNT_W-1:0]    r_cnt   [NUM_KEYS];
    t_phase              r_phase [NUM_KEYS];
    logic [TMR_W-1:0]    r_timer [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_stable;

    // Event queue.
    logic [KEY_W-1:0]  r_store [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W-1:0] r_wr_ptr;

    // Result register.
    logic                r_out_valid;
    logic                r_ev_valid;
    logic [KEY_W-1:0]    r_ev_key;
    logic [NUM_KEYS-1:0] r_out_stable;
    logic                r_qempty;
    logic [DROP_W-1:0]   r_dropped;

    // Next-state values.
    logic [CNT_W-1:0]    n_cnt   [NUM_KEYS];
    t_phase              n_phase [NUM_KEYS];
    logic [TMR_W-1:0]    n_timer [NUM_KEYS];
    logic [NUM_KEYS-1:0] n_stable;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic                n_ev_valid;
    logic [KEY_W-1:0]    n_ev_key;
    logic [DROP_W-1:0]   n_dropped;

    // Push candidates, presses first and then repeats, each in key order.
    logic [CAND_N-1:0]   w_cand;
    logic [KEY_W-1:0]    w_cand_key  [CAND_N];
    logic [CMP_W-1:0]    w_pos       [CAND_N];
    logic [CAND_N-1:0]   w_push_en;
    logic [QPTR_W-1:0]   w_push_addr [CAND_N];
    logic [NUM_KEYS-1:0] w_press;
    logic [NUM_KEYS-1:0] w_rep_push;

    logic [CMP_W-1:0]    w_count;
    logic [CMP_W-1:0]    w_free;
    logic [CMP_W-1:0]    w_total;
    logic [CMP_W-1:0]    w_accepted;
    logic [CMP_W-1:0]    w_wr_sum;
    logic                w_adv;
    logic                w_in_accept;
    logic                w_scan;
    logic                w_pop;
    logic                w_not_empty;

    // Handshake: the input register moves on when the result register is free or drained.
    assign w_adv       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_scan      = w_adv && (r_func == FUNC_SCAN);
    assign w_pop       = w_adv && (r_func == FUNC_POP);
    assign w_not_empty = (r_rd_ptr != r_wr_ptr);

    // Queue fill level and free slots (one slot always stays unused).
    always_comb begin
        if (r_wr_ptr >= r_rd_ptr) begin
            w_count = CMP_W'(r_wr_ptr) - CMP_W'(r_rd_ptr);
        end else begin
            w_count = CMP_W'(r_wr_ptr) + CMP_W'(QUEUE_DEPTH) - CMP_W'(r_rd_ptr);
        end
        w_free = CMP_W'(QUEUE_DEPTH - 1) - w_count;
    end

    // Per-key debounce counter, stable bit, and repeat timer update.
    always_comb begin
        for (int i = 0; i < NUM_KEYS; i++) begin
            n_cnt[i]      = r_cnt[i];
            n_stable[i]   = r_stable[i];
            n_phase[i]    = r_phase[i];
            n_timer[i]    = r_timer[i];
            w_rep_push[i] = 1'b0;

            // Up/down counter with saturation at the debounce count.
            if (r_raw[i]) begin
                if (r_cnt[i] < r_debounce) begin
                    n_cnt[i] = r_cnt[i] + CNT_W'(1);
                    if (n_cnt[i] >= r_debounce) begin
                        n_stable[i] = 1'b1;
                    end
                end
            end else if (r_cnt[i] != '0) begin
                n_cnt[i] = r_cnt[i] - CNT_W'(1);
                if (r_cnt[i] == CNT_W'(1)) begin
                    n_stable[i] = 1'b0;
                    n_phase[i]  = PH_IDLE;
                    n_timer[i]  = '0;
                end
            end

            // A rising stable edge starts the delay phase.
            w_press[i] = n_stable[i] && !r_stable[i];
            if (w_press[i]) begin
                n_phase[i] = PH_DELAY;
                n_timer[i] = r_delay;
            end

            // Timer service for held keys.
            if (n_stable[i] && (n_phase[i] != PH_IDLE)) begin
                if (n_timer[i] != '0) begin
                    n_timer[i] = n_timer[i] - TMR_W'(1);
                end else if (n_phase[i] == PH_DELAY) begin
                    n_phase[i] = PH_REPEAT;
                    n_timer[i] = r_rate;
                end else begin
                    w_rep_push[i] = 1'b1;
                    n_timer[i]    = r_rate;
                end
            end
        end
    end

    // Push compaction: each candidate takes the slot given by its prefix count.
    always_comb begin
        w_cand = {w_rep_push, w_press};
        for (int j = 0; j < CAND_N; j++) begin
            w_cand_key[j]  = KEY_W'(j % NUM_KEYS);
            w_pos[j]       = CMP_W'($countones(w_cand & ((CAND_N'(1) << j) - CAND_N'(1))));
            w_push_en[j]   = w_cand[j] && (w_pos[j] < w_free);
            w_wr_sum       = CMP_W'(r_wr_ptr) + w_pos[j];
            if (w_wr_sum >= CMP_W'(QUEUE_DEPTH)) begin
                w_wr_sum = w_wr_sum - CMP_W'(QUEUE_DEPTH);
            end
            w_push_addr[j] = w_wr_sum[QPTR_W-1:0];
        end
        w_total    = CMP_W'($countones(w_cand));
        w_accepted = (w_total < w_free) ? w_total : w_free;
        w_wr_sum   = CMP_W'(r_wr_ptr) + w_accepted;
        if (w_wr_sum >= CMP_W'(QUEUE_DEPTH)) begin
            w_wr_sum = w_wr_sum - CMP_W'(QUEUE_DEPTH);
        end
    end

    // Pointer updates and result fields.
    always_comb begin
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_ev_valid = 1'b0;
        n_ev_key   = '0;
        n_dropped  = '0;
        if (r_func == FUNC_POP) begin
            if (w_not_empty) begin
                n_ev_valid = 1'b1;
                n_ev_key   = r_store[r_rd_ptr];
                n_rd_ptr   = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : r_rd_ptr + QPTR_W'(1);
            end
        end else begin
            n_wr_ptr  = w_wr_sum[QPTR_W-1:0];
            n_dropped = DROP_W'(w_total - w_accepted);
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= RST_DEBOUNCE;
            r_delay    <= RST_DELAY;
            r_rate     <= RST_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data[CNT_W-1:0];
                CFG_DELAY:    r_delay    <= i_cfg_data[TMR_W-1:0];
                CFG_RATE:     r_rate     <= i_cfg_data[TMR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
        if (w_in_accept) begin
            r_func <= i_func;
            r_raw  <= i_raw_keys;
        end
    end

    // Key state and queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_cnt[i]   <= '0;
                r_phase[i] <= PH_IDLE;
                r_timer[i] <= '0;
            end
            r_stable <= '0;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
        end else begin
            if (w_scan) begin
                for (int i = 0; i < NUM_KEYS; i++) begin
                    r_cnt[i]   <= n_cnt[i];
                    r_phase[i] <= n_phase[i];
                    r_timer[i] <= n_timer[i];
                end
                r_stable <= n_stable;
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
        end
    end

    // Event store: up to one word per candidate is written, each at its own slot.
    always_ff @(posedge i_clk) begin
        if (w_scan) begin
            for (int j = 0; j < CAND_N; j++) begin
                if (w_push_en[j]) begin
                    r_store[w_push_addr[j]] <= w_cand_key[j];
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv) begin
            r_ev_valid   <= n_ev_valid;
            r_ev_key     <= n_ev_key;
            r_out_stable <= (r_func == FUNC_SCAN) ? n_stable : r_stable;
            r_qempty     <= (n_rd_ptr == n_wr_ptr);
            r_dropped    <= n_dropped;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_valid    = r_ev_valid;
    assign o_event_key      = r_ev_key;
    assign o_stable_keys    = r_out_stable;
    assign o_queue_empty    = r_qempty;
    assign o_dropped_events = r_dropped;

`ifndef SYNTHESIS
    // Summary vectors for the checks below.
    logic [NUM_KEYS-1:0] w_chk_cnt_nz;
    logic [NUM_KEYS-1:0] w_chk_active;

    always_comb begin
        for (int i = 0; i < NUM_KEYS; i++) begin
            w_chk_cnt_nz[i] = (r_cnt[i] != '0);
            w_chk_active[i] = (r_phase[i] != PH_IDLE);
        end
    end

    // A key in the delay or repeat phase must be stable-pressed.
    a_active_is_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_chk_active & ~r_stable) == '0)
        else $error("repeat phase active on a released key");

    // A stable-pressed key always has a nonzero debounce counter.
    a_stable_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stable & ~w_chk_cnt_nz) == '0)
        else $error("stable key with zero debounce counter");

    // Events are dropped only when the scan leaves the queue full.
    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan |=> (o_dropped_events == '0) ||
                   (w_count == CMP_W'(QUEUE_DEPTH - 1)))
        else $error("event dropped while the queue had room");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the multi-key debounce and auto-repeat unit.
`timescale 1ns / 1ps

import mkdar_pkg::*;

// One output word of the unit, packed in port order.
typedef struct packed {
    logic                ev_valid;
    logic [KEY_W-1:0]    ev_key;
    logic [NUM_KEYS-1:0] stable;
    logic                empty;
    logic [DROP_W-1:0]   dropped;
} t_report;

// Tracks keys, repeat timers and the event queue, and checks every output word.
class key_event_board;
    logic [CNT_W-1:0]    bounce_cnt [NUM_KEYS];
    t_phase              key_phase [NUM_KEYS];
    logic [TMR_W-1:0]    key_timer [NUM_KEYS];
    logic [NUM_KEYS-1:0] stable_now;
    logic [NUM_KEYS-1:0] stable_prev;
    logic [KEY_W-1:0]    event_slots [QUEUE_DEPTH];
    int unsigned         rd_slot;
    int unsigned         wr_slot;
    logic [CNT_W-1:0]    cfg_debounce;
    logic [TMR_W-1:0]    cfg_delay;
    logic [TMR_W-1:0]    cfg_rate;
    t_report             expected_words [$];
    int                  failures;

    function new();
        for (int k = 0; k < NUM_KEYS; k++) begin
            bounce_cnt[k] = '0;
            key_phase[k] = PH_IDLE;
            key_timer[k] = '0;
        end
        stable_now = '0;
        stable_prev = '0;
        rd_slot = 0;
        wr_slot = 0;
        cfg_debounce = RST_DEBOUNCE;
        cfg_delay = RST_DELAY;
        cfg_rate = RST_RATE;
        failures = 0;
    endfunction

    function void set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            CFG_DEBOUNCE: cfg_debounce = data[CNT_W-1:0];
            CFG_DELAY:    cfg_delay = data;
            CFG_RATE:     cfg_rate = data;
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    function void flag(input string what);
        failures++;
        if (failures <= 10) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endfunction

    // Stores a key event; returns 0 when the queue is full and the event is lost.
    function bit enqueue_key(input int key);
        int unsigned nxt;
        nxt = (wr_slot + 1 >= QUEUE_DEPTH) ? 0 : wr_slot + 1;
        if (nxt == rd_slot) begin
            return 1'b0;
        end
        event_slots[wr_slot] = KEY_W'(key);
        wr_slot = nxt;
        return 1'b1;
    endfunction

    // Works out the output word for one accepted input word.
    function void note_word(input logic func, input logic [NUM_KEYS-1:0] raw);
        t_report             want;
        logic [NUM_KEYS-1:0] pressed_now;
        want = '0;
        if (func == FUNC_POP) begin
            if (rd_slot != wr_slot) begin
                want.ev_valid = 1'b1;
                want.ev_key = event_slots[rd_slot];
                rd_slot = (rd_slot + 1 >= QUEUE_DEPTH) ? 0 : rd_slot + 1;
            end
        end else begin
            // Debounce counters first.
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (raw[k]) begin
                    if (bounce_cnt[k] < cfg_debounce) begin
                        bounce_cnt[k]++;
                        if (bounce_cnt[k] >= cfg_debounce) begin
                            stable_now[k] = 1'b1;
                        end
                    end
                end else if (bounce_cnt[k] != 0) begin
                    bounce_cnt[k]--;
                    if (bounce_cnt[k] == 0) begin
                        stable_now[k] = 1'b0;
                        key_phase[k] = PH_IDLE;
                        key_timer[k] = '0;
                    end
                end
            end
            // New presses are queued in key order and start the delay.
            pressed_now = stable_now & ~stable_prev;
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (pressed_now[k]) begin
                    if (!enqueue_key(k)) begin
                        want.dropped++;
                    end
                    key_phase[k] = PH_DELAY;
                    key_timer[k] = cfg_delay;
                end
            end
            // Repeat timers of held keys, including the ones just pressed.
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (stable_now[k] && key_phase[k] != PH_IDLE) begin
                    if (key_timer[k] != 0) begin
                        key_timer[k]--;
                    end else if (key_phase[k] == PH_DELAY) begin
                        key_phase[k] = PH_REPEAT;
                        key_timer[k] = cfg_rate;
                    end else begin
                        if (!enqueue_key(k)) begin
                            want.dropped++;
                        end
                        key_timer[k] = cfg_rate;
                    end
                end
            end
            stable_prev = stable_now;
        end
        want.stable = stable_now;
        want.empty = (rd_slot == wr_slot);
        expected_words.push_back(want);
    endfunction

    function void check_field(input string name, input int unsigned want, input int unsigned seen);
        if (want != seen) begin
            flag($sformatf("%s expected %0d, got %0d", name, want, seen));
        end
    endfunction

    // Compares one accepted output word with the oldest expectation.
    function void check_word(input t_report seen);
        t_report want;
        if (expected_words.size() == 0) begin
            flag("output word arrived with nothing expected");
            return;
        end
        want = expected_words.pop_front();
        check_field("event_valid", want.ev_valid, seen.ev_valid);
        check_field("event_key", want.ev_key, seen.ev_key);
        check_field("stable_keys", want.stable, seen.stable);
        check_field("queue_empty", want.empty, seen.empty);
        check_field("dropped_events", want.dropped, seen.dropped);
    endfunction
endclass

module testbench;
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_DEBOUNCE;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_func = FUNC_SCAN;
    logic [NUM_KEYS-1:0]  i_raw_keys = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_event_valid;
    logic [KEY_W-1:0]     o_event_key;
    logic [NUM_KEYS-1:0]  o_stable_keys;
    logic                 o_queue_empty;
    logic [DROP_W-1:0]    o_dropped_events;

    key_event_board       board = new();
    logic [NUM_KEYS-1:0]  held_keys = '0;
    bit                   calm = 1'b0;
    int                   hold_request = 0;

    multi_key_debounce_autorepeat_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_raw_keys       (i_raw_keys),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_valid    (o_event_valid),
        .o_event_key      (o_event_key),
        .o_stable_keys    (o_stable_keys),
        .o_queue_empty    (o_queue_empty),
        .o_dropped_events (o_dropped_events)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Offers one word, with random idle cycles ahead of it, and waits for acceptance.
    task automatic send_word(input logic func, input logic [NUM_KEYS-1:0] raw);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= func;
        i_raw_keys <= raw;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        board.note_word(func, raw);
    endtask

    // Stops offering words until every expected word has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() > 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        board.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_timing(input int debounce, input int delay, input int rate);
        write_register(CFG_DEBOUNCE, CFG_W'(debounce));
        write_register(CFG_DELAY, CFG_W'(delay));
        write_register(CFG_RATE, CFG_W'(rate));
    endtask

    // Keys held for long stretches with contact bounce on top, mixed with pops.
    task automatic run_phase(input int count);
        logic [NUM_KEYS-1:0] bounce;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 30) begin
                send_word(FUNC_POP, NUM_KEYS'($urandom));
            end else begin
                if ($urandom_range(99) < 15) begin
                    held_keys[$urandom_range(NUM_KEYS - 1)] ^= 1'b1;
                end
                if ($urandom_range(199) == 0) begin
                    held_keys = ($urandom_range(1) != 0) ? '1 : '0;
                end
                bounce = ($urandom_range(99) < 10) ? NUM_KEYS'($urandom & $urandom) : '0;
                send_word(FUNC_SCAN, held_keys ^ bounce);
            end
        end
    endtask

    // Output side: checks accepted words and stalls at random or for a requested hold-off.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                board.check_word({o_event_valid, o_event_key, o_stable_keys,
                                  o_queue_empty, o_dropped_events});
            end
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 15);
            end
        end
    end

    // Main sequence.
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset timing: empty pop, all keys, release, overflow.
        send_word(FUNC_POP, '0);
        repeat (3) send_word(FUNC_SCAN, '1);
        repeat (3) send_word(FUNC_SCAN, '0);
        repeat (3) send_word(FUNC_SCAN, '1);
        repeat (16) send_word(FUNC_POP, '0);
        drain_results();

        // Shortest timing: a repeat on every scan floods the queue.
        set_timing(1, 0, 0);
        run_phase(200);
        drain_results();

        // Longest timing.
        set_timing(15, 16'hFFFF, 16'hFFFF);
        run_phase(200);
        drain_results();

        // Count lowered below held counters; the output side holds off for a long stretch.
        set_timing(4, 3, 1);
        hold_request = 80;
        run_phase(200);
        drain_results();

        // A zero count lets keys only release.
        set_timing(0, 2, 0);
        run_phase(150);
        drain_results();

        // No idling on either side.
        calm = 1'b1;
        set_timing(2, 5, 2);
        run_phase(200);
        drain_results();
        calm = 1'b0;

        // Random timings.
        repeat (3) begin
            set_timing($urandom_range(15, 1), $urandom_range(12), $urandom_range(6));
            run_phase(225);
            drain_results();
        end

        @(negedge i_clk);
        for (int c = 0; c < 5000 && board.pending() > 0; c++) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
        if (board.pending() > 0) begin
            board.flag($sformatf("%0d expected words never arrived", board.pending()));
        end
        if (board.failures == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end
endmodule
